[sv/obst_pkg.sv]
`timescale 1ns / 1ps
// shared constants, command codes and types for the optimal search tree cost block
package obst_pkg;

   localparam int MAX_KEYS_DEF  = 64;
   localparam int FREQ_BITS_DEF = 16;

   // fixed field widths of the stream beats
   localparam int FREQ_IN_W  = 16;
   localparam int COST_OUT_W = 28;
   localparam int KEY_OUT_W  = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [COST_OUT_W-1:0] COST_SAT = '1;

   // datapath operation codes
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP    = 4'd0;
   localparam op_type OP_LOAD   = 4'd1;
   localparam op_type OP_ZERO   = 4'd2;
   localparam op_type OP_DIAG   = 4'd3;
   localparam op_type OP_RD_LO  = 4'd4;
   localparam op_type OP_RD_HI  = 4'd5;
   localparam op_type OP_CAP    = 4'd6;
   localparam op_type OP_START  = 4'd7;
   localparam op_type OP_KREAD  = 4'd8;
   localparam op_type OP_KCMP   = 4'd9;
   localparam op_type OP_WRITE  = 4'd10;
   localparam op_type OP_RD_OUT = 4'd11;
   localparam op_type OP_OUT    = 4'd12;

   typedef struct packed {
      op_type op;
      logic   ovf;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

[sv/obst_datapath.sv]
`timescale 1ns / 1ps
// tables, prefix sums, candidate compare and result register
module obst_datapath #(
   parameter int MAX_KEYS  = obst_pkg::MAX_KEYS_DEF,
   parameter int FREQ_BITS = obst_pkg::FREQ_BITS_DEF,
   parameter int IW        = $clog2(MAX_KEYS + 2)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  obst_pkg::cmd_type                   cmd,
   input  logic [IW-1:0]                       idx_i,
   input  logic [IW-1:0]                       idx_j,
   input  logic [IW-1:0]                       idx_k,
   input  logic [IW-1:0]                       count,
   input  logic [obst_pkg::FREQ_IN_W-1:0]      freq_in,
   output logic [IW-1:0]                       root_rd,
   output obst_pkg::sts_type                   sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [obst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int PW    = FREQ_BITS + $clog2(MAX_KEYS + 1);
   localparam int CW    = PW + $clog2(MAX_KEYS + 1);
   localparam int SW    = (CW > obst_pkg::COST_OUT_W) ? CW : obst_pkg::COST_OUT_W;
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int LDEP  = 1 << IW;

   logic [FREQ_BITS-1:0] freq_mem [LDEP];
   logic [PW-1:0]        pre_mem  [LDEP];
   logic [CW-1:0]        cost_mem [DEPTH];
   logic [IW-1:0]        root_mem [DEPTH];

   logic [FREQ_BITS-1:0] freq_rd_ff;
   logic [PW-1:0]        pre_rd_ff;
   logic [CW-1:0]        cost_a_ff, cost_b_ff;
   logic [IW-1:0]        root_rd_ff;

   logic [PW-1:0]        psum_ff, psum_in;
   logic [PW-1:0]        pj_ff, pi1_ff;
   logic [CW:0]          best_ff, best_in;
   logic [IW-1:0]        bestk_ff, bestk_in;
   logic                 valid_ff, valid_in;
   logic [obst_pkg::RSP_DATA_W-1:0] data_ff, data_in;
   logic                 user_ff, user_in;

   logic [FREQ_BITS-1:0] freq_w;
   logic [IW-1:0]        ld_idx;
   logic [IW-1:0]        a_col, root_row, root_col, pre_addr;
   logic [CW:0]          cand;
   logic [CW-1:0]        cost_new;
   logic [SW-1:0]        cost_ext;
   logic [obst_pkg::COST_OUT_W-1:0] cost_sat;
   logic                 cost_we, root_we;
   logic [AW-1:0]        cost_wa;
   logic [CW-1:0]        cost_wd;
   logic [IW-1:0]        root_wd;

   assign freq_w  = FREQ_BITS'(freq_in);
   assign ld_idx  = count + IW'(1);
   assign cand    = {1'b0, cost_a_ff} + {1'b0, cost_b_ff};
   assign cost_new = CW'(pj_ff - pi1_ff) + best_ff[CW-1:0];
   assign a_col   = (cmd.op == obst_pkg::OP_KREAD) ? idx_k - IW'(1) : idx_j - IW'(1);
   assign root_row = (cmd.op == obst_pkg::OP_RD_HI) ? idx_i + IW'(1) : idx_i;
   assign root_col = (cmd.op == obst_pkg::OP_RD_HI) ? idx_j : idx_j - IW'(1);
   assign pre_addr = (cmd.op == obst_pkg::OP_RD_HI) ? idx_i - IW'(1) : idx_j;
   assign cost_ext = SW'(cost_a_ff);
   assign cost_sat = (cost_ext > SW'(obst_pkg::COST_SAT)) ? obst_pkg::COST_SAT
                                                          : obst_pkg::COST_OUT_W'(cost_a_ff);

   // table write selection
   always_comb begin
      cost_we = 1'b0;
      root_we = 1'b0;
      cost_wa = {idx_i, idx_j};
      cost_wd = cost_new;
      root_wd = bestk_ff;
      case (cmd.op)
         obst_pkg::OP_ZERO: begin
            cost_we = 1'b1;
            cost_wa = {idx_i, idx_i - IW'(1)};
            cost_wd = '0;
         end
         obst_pkg::OP_DIAG: begin
            cost_we = 1'b1;
            root_we = 1'b1;
            cost_wa = {idx_i, idx_i};
            cost_wd = CW'(freq_rd_ff);
            root_wd = idx_i;
         end
         obst_pkg::OP_WRITE: begin
            cost_we = 1'b1;
            root_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (cmd.op == obst_pkg::OP_LOAD) begin
         freq_mem[ld_idx] <= freq_w;
         pre_mem[ld_idx]  <= psum_ff + PW'(freq_w);
      end
      if (cost_we) begin
         cost_mem[cost_wa] <= cost_wd;
      end
      if (root_we) begin
         root_mem[cost_wa] <= root_wd;
      end
      freq_rd_ff <= freq_mem[idx_i];
      pre_rd_ff  <= pre_mem[pre_addr];
      cost_a_ff  <= cost_mem[{idx_i, a_col}];
      cost_b_ff  <= cost_mem[{idx_k + IW'(1), idx_j}];
      root_rd_ff <= root_mem[{root_row, root_col}];
   end

   // running sum, candidate minimum, result register
   always_comb begin
      psum_in  = psum_ff;
      best_in  = best_ff;
      bestk_in = bestk_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      case (cmd.op)
         obst_pkg::OP_LOAD:  psum_in = psum_ff + PW'(freq_w);
         obst_pkg::OP_START: best_in = '1;
         obst_pkg::OP_KCMP: begin
            if (cand <= best_ff) begin
               best_in  = cand;
               bestk_in = idx_k;
            end
         end
         obst_pkg::OP_OUT: begin
            psum_in  = '0;
            valid_in = 1'b1;
            data_in  = {6'd0, obst_pkg::KEY_OUT_W'(count),
                        obst_pkg::KEY_OUT_W'(root_rd_ff), cost_sat};
            user_in  = cmd.ovf;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         psum_ff  <= psum_in;
         valid_ff <= valid_in;
      end
      best_ff  <= best_in;
      bestk_ff <= bestk_in;
      data_ff  <= data_in;
      user_ff  <= user_in;
      if (cmd.op == obst_pkg::OP_RD_HI) begin
         pj_ff <= pre_rd_ff;
      end
      if (cmd.op == obst_pkg::OP_CAP) begin
         pi1_ff <= (idx_i == IW'(1)) ? '0 : pre_rd_ff;
      end
   end

   assign root_rd      = root_rd_ff;
   assign sts.out_busy = valid_ff && !rsp_tready;
   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser    = user_ff;

endmodule

[sv/obst_ctrl.sv]
`timescale 1ns / 1ps
// sequencer for key loading and the interval sweep
module obst_ctrl #(
   parameter int MAX_KEYS = obst_pkg::MAX_KEYS_DEF,
   parameter int IW       = $clog2(MAX_KEYS + 2)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tlast,
   input  logic [IW-1:0]     root_rd,
   input  obst_pkg::sts_type sts,
   output obst_pkg::cmd_type cmd,
   output logic [IW-1:0]     idx_i,
   output logic [IW-1:0]     idx_j,
   output logic [IW-1:0]     idx_k,
   output logic [IW-1:0]     count
);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_INITA = 4'd1;
   localparam logic [3:0] S_INITB = 4'd2;
   localparam logic [3:0] S_NEXT  = 4'd3;
   localparam logic [3:0] S_R1    = 4'd4;
   localparam logic [3:0] S_R2    = 4'd5;
   localparam logic [3:0] S_R3    = 4'd6;
   localparam logic [3:0] S_R4    = 4'd7;
   localparam logic [3:0] S_KR    = 4'd8;
   localparam logic [3:0] S_KC    = 4'd9;
   localparam logic [3:0] S_WR    = 4'd10;
   localparam logic [3:0] S_OUT1  = 4'd11;
   localparam logic [3:0] S_OUT2  = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, lo_ff, lo_in, hi_ff, hi_in;
   logic          keep;

   assign keep = cnt_ff < IW'(MAX_KEYS);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      req_tready = 1'b0;
      cmd.op     = obst_pkg::OP_NOP;
      cmd.ovf    = ovf_ff;
      case (state_ff)
         // take key beats
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (keep) begin
                  cmd.op = obst_pkg::OP_LOAD;
                  cnt_in = cnt_ff + IW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  i_in     = IW'(1);
                  state_in = S_INITA;
               end
            end
         end
         // zero the empty intervals, fetch the key weight
         S_INITA: begin
            cmd.op = obst_pkg::OP_ZERO;
            if (i_ff == cnt_ff + IW'(1)) begin
               i_in     = cnt_ff;
               j_in     = cnt_ff + IW'(1);
               state_in = S_NEXT;
            end else begin
               state_in = S_INITB;
            end
         end
         S_INITB: begin
            cmd.op   = obst_pkg::OP_DIAG;
            i_in     = i_ff + IW'(1);
            state_in = S_INITA;
         end
         // advance over intervals, rows from the bottom
         S_NEXT: begin
            if (j_ff > cnt_ff) begin
               if (i_ff == IW'(1)) begin
                  state_in = S_OUT1;
               end else begin
                  i_in = i_ff - IW'(1);
                  j_in = i_ff;
               end
            end else begin
               state_in = S_R1;
            end
         end
         S_R1: begin
            cmd.op   = obst_pkg::OP_RD_LO;
            state_in = S_R2;
         end
         S_R2: begin
            cmd.op   = obst_pkg::OP_RD_HI;
            lo_in    = root_rd;
            state_in = S_R3;
         end
         S_R3: begin
            cmd.op   = obst_pkg::OP_CAP;
            hi_in    = root_rd;
            state_in = S_R4;
         end
         // knuth bound check, fall back to the full range
         S_R4: begin
            cmd.op = obst_pkg::OP_START;
            if (lo_ff < i_ff || hi_ff > j_ff || lo_ff > hi_ff) begin
               k_in  = i_ff;
               hi_in = j_ff;
            end else begin
               k_in = lo_ff;
            end
            state_in = S_KR;
         end
         S_KR: begin
            cmd.op   = obst_pkg::OP_KREAD;
            state_in = S_KC;
         end
         S_KC: begin
            cmd.op = obst_pkg::OP_KCMP;
            k_in   = k_ff + IW'(1);
            state_in = (k_ff == hi_ff) ? S_WR : S_KR;
         end
         S_WR: begin
            cmd.op   = obst_pkg::OP_WRITE;
            j_in     = j_ff + IW'(1);
            state_in = S_NEXT;
         end
         // wait for the result register, then post the beat
         S_OUT1: begin
            cmd.op = obst_pkg::OP_RD_OUT;
            if (!sts.out_busy) begin
               state_in = S_OUT2;
            end
         end
         S_OUT2: begin
            cmd.op   = obst_pkg::OP_OUT;
            cnt_in   = '0;
            ovf_in   = 1'b0;
            state_in = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign idx_i = i_ff;
   assign idx_j = j_ff;
   assign idx_k = k_ff;
   assign count = cnt_ff;

endmodule

[sv/optimal_bst_cost.sv]
`timescale 1ns / 1ps
// top level of the optimal binary search tree cost block
// Key frequencies are taken one beat per cycle. The beat with tlast closes the
// batch; no further beat is taken until the result is posted. Setup zeroes the
// empty intervals and writes the diagonal, the sweep then steps over the rows
// from the bottom, and posting the result waits while the receiver still holds
// the previous one. Each interval reads its bounding roots and prefix sums, then
// reads and compares every candidate root in turn, since every candidate needs a
// registered read of the cost table before its compare, and writes its cost and
// root. Keys past MAX_KEYS are dropped and flagged in tuser.
module optimal_bst_cost #(
   parameter int MAX_KEYS  = obst_pkg::MAX_KEYS_DEF,
   parameter int FREQ_BITS = obst_pkg::FREQ_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [obst_pkg::REQ_DATA_W-1:0]   req_tdata,  // freq_value
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [obst_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // min_cost, root_key, key_count
   output logic                              rsp_tuser   // overflow_flag
);

   localparam int IW = $clog2(MAX_KEYS + 2);

   obst_pkg::cmd_type cmd;
   obst_pkg::sts_type sts;
   logic [IW-1:0]     idx_i, idx_j, idx_k, count, root_rd;

   obst_ctrl #(.MAX_KEYS(MAX_KEYS), .IW(IW)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tlast(req_tlast),
      .root_rd(root_rd), .sts(sts), .cmd(cmd),
      .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .count(count)
   );

   obst_datapath #(.MAX_KEYS(MAX_KEYS), .FREQ_BITS(FREQ_BITS), .IW(IW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .count(count),
      .freq_in(req_tdata), .root_rd(root_rd), .sts(sts),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule

[sv/obst_checker.sv]
`timescale 1ns / 1ps
// port checker for the optimal search tree cost block, bound to the top level
module obst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [obst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // closing beat stops intake while the sweep runs
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after closing beat");

   // no result out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a rising result is always preceded by closed intake
   a_rsp_after_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result posted without a sweep");

endmodule

bind optimal_bst_cost obst_checker u_obst_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tlast(req_tlast),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the optimal binary search tree cost block
module testbench;

   typedef struct packed {
      logic [27:0] cost;
      logic [6:0]  root;
      logic [6:0]  count;
      logic        ovf;
   } tree_result_type;

   typedef struct {
      logic [15:0] freq;
      logic        last;
      logic        has_exp;
      tree_result_type exp;
   } stim_row_type;

   localparam int NKEYS = obst_pkg::MAX_KEYS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [obst_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [obst_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   optimal_bst_cost i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] key_freq [1:NKEYS];
   logic [21:0] freq_prefix [0:NKEYS];
   int unsigned key_cnt;
   logic        key_ovf;
   tree_result_type tree_expected [$];
   stim_row_type    stim_rows [$];

   int errors = 0;
   int results_seen = 0;
   int batches_sent = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit rsp_hold = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // full Knuth-bounded cost table sweep for the held batch
   function automatic tree_result_type compute_tree();
      longint unsigned cost [0:NKEYS+1][0:NKEYS+1];
      int unsigned root [0:NKEYS+1][0:NKEYS+1];
      tree_result_type r;
      int unsigned n, lo, hi, bk;
      longint unsigned best, t;
      n = key_cnt;
      for (int a = 0; a <= NKEYS + 1; a++)
         for (int b = 0; b <= NKEYS + 1; b++) begin
            cost[a][b] = 0;
            root[a][b] = 0;
         end
      for (int i = 1; i <= n; i++) begin
         cost[i][i] = key_freq[i];
         root[i][i] = i;
      end
      for (int i = n; i >= 1; i--)
         for (int j = i + 1; j <= n; j++) begin
            lo = root[i][j-1];
            hi = root[i+1][j];
            best = '1;
            bk = lo;
            if (lo < i || hi > j || lo > hi) begin
               lo = i;
               hi = j;
               bk = i;
            end
            for (int k = lo; k <= hi; k++) begin
               t = cost[i][k-1] + cost[k+1][j];
               if (t <= best) begin
                  best = t;
                  bk = k;
               end
            end
            cost[i][j] = freq_prefix[j] - freq_prefix[i-1] + best;
            root[i][j] = bk;
         end
      r.cost  = (cost[1][n] > 64'hFFFFFFF) ? obst_pkg::COST_SAT : cost[1][n][27:0];
      r.root  = root[1][n][6:0];
      r.count = n[6:0];
      r.ovf   = key_ovf;
      return r;
   endfunction

   // update the predictor with one accepted key beat
   function automatic void take_key(input logic [15:0] f, input logic last,
                                    input logic has_exp, input tree_result_type exp);
      tree_result_type r;
      if (key_cnt < NKEYS) begin
         key_cnt++;
         key_freq[key_cnt] = f;
         freq_prefix[key_cnt] = freq_prefix[key_cnt-1] + f;
      end else
         key_ovf = 1'b1;
      if (last) begin
         r = compute_tree();
         if (has_exp && r != exp) begin
            $display("table row disagrees with predictor");
            errors++;
         end
         tree_expected.push_back(has_exp ? exp : r);
         key_cnt = 0;
         key_ovf = 1'b0;
         batches_sent++;
      end
   endfunction

   // drive one key beat, hold until taken; valid is dropped by the next idle
   task automatic send_key(input logic [15:0] f, input logic last,
                           input logic has_exp = 1'b0, input tree_result_type exp = '0);
      while (req_idle_pct > 0 && $urandom_range(99, 0) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      take_key(f, last, has_exp, exp);
      @(negedge clock);
   endtask

   // stop offering beats and wait for every pending result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tree_expected.size() != 0) @(negedge clock);
   endtask

   function automatic tree_result_type row_exp(int c, int r, int n, bit o);
      tree_result_type e;
      e.cost = c[27:0]; e.root = r[6:0]; e.count = n[6:0]; e.ovf = o;
      return e;
   endfunction

   function automatic void add_row(logic [15:0] f, logic l, logic h = 1'b0,
                                   tree_result_type e = '0);
      stim_row_type s;
      s.freq = f; s.last = l; s.has_exp = h; s.exp = e;
      stim_rows.push_back(s);
   endfunction

   // random batch: mostly small sizes, a few near or past capacity
   task automatic random_batch(output int sent);
      int n, sel;
      logic [15:0] f;
      sel = $urandom_range(99, 0);
      if (sel < 80) n = $urandom_range(12, 1);
      else if (sel < 95) n = $urandom_range(30, 13);
      else n = $urandom_range(NKEYS + 6, NKEYS - 2);
      for (int k = 1; k <= n; k++) begin
         case ($urandom_range(3, 0))
            0: f = 16'($urandom_range(65535, 0));
            1: f = 16'($urandom_range(15, 0));
            2: f = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            default: f = 16'($urandom_range(1000, 0));
         endcase
         send_key(f, k == n);
      end
      sent = n;
   endtask

   // result checker
   always @(posedge clock) begin
      tree_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cost  = rsp_tdata[27:0];
         got.root  = rsp_tdata[34:28];
         got.count = rsp_tdata[41:35];
         got.ovf   = rsp_tuser;
         if (tree_expected.size() == 0) begin
            $display("unexpected result beat at %0t", $realtime);
            errors++;
         end else begin
            want = tree_expected.pop_front();
            if (got.cost != want.cost) report_mismatch("min_cost", got.cost, want.cost);
            if (got.root != want.root) report_mismatch("root_key", got.root, want.root);
            if (got.count != want.count)
               report_mismatch("key_count", got.count, want.count);
            if (got.ovf != want.ovf) report_mismatch("overflow_flag", got.ovf, want.ovf);
         end
         results_seen++;
      end
   end

   // receiver ready pattern
   always @(negedge clock) begin
      if (rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !(rsp_idle_pct > 0 && $urandom_range(99, 0) < rsp_idle_pct);
   end

   // run limit
   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int sent, total;
      key_cnt = 0;
      key_ovf = 1'b0;
      freq_prefix[0] = '0;
      total = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single keys, extremes, a small tree, capacity overflow
      add_row(16'd0, 1'b1, 1'b1, row_exp(0, 1, 1, 0));
      add_row(16'hFFFF, 1'b1, 1'b1, row_exp(65535, 1, 1, 0));
      add_row(16'd5, 1'b0);
      add_row(16'd5, 1'b1, 1'b1, row_exp(15, 2, 2, 0));
      add_row(16'd34, 1'b0);
      add_row(16'd8, 1'b0);
      add_row(16'd50, 1'b1);
      add_row(16'h8000, 1'b0);
      add_row(16'h7FFF, 1'b0);
      add_row(16'h0001, 1'b1);
      foreach (stim_rows[r]) begin
         send_key(stim_rows[r].freq, stim_rows[r].last, stim_rows[r].has_exp,
                  stim_rows[r].exp);
         total++;
      end
      // full capacity of max-frequency keys plus dropped extras
      for (int k = 1; k <= NKEYS + 3; k++) begin
         send_key(16'hFFFF, k == NKEYS + 3);
         total++;
      end
      wait_drained();

      // random phases with changing idle mixes
      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 67 : 0;
         rsp_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 36 : 0;
         while (total < 130 * (ph + 1)) begin
            random_batch(sent);
            total += sent;
         end
         // sender pause until every result is in
         wait_drained();
      end

      // long receiver stall while batches keep coming
      fork
         begin
            rsp_hold = 1'b1;
            repeat (3000) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            for (int b = 0; b < 4; b++) begin
               send_key(16'd7, 1'b0);
               send_key(16'd3, 1'b1);
               total += 2;
            end
            wait_drained();
         end
      join
      repeat (100) @(posedge clock);

      $display("covered %0d key beats in %0d batches, %0d results checked",
               total, batches_sent, results_seen);
      $display("single keys, extremes, full capacity with overflow, stalls on both sides");
      if (errors == 0 && tree_expected.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

[optimal_bst_cost.f]
sv/obst_pkg.sv
sv/obst_datapath.sv
sv/obst_ctrl.sv
sv/optimal_bst_cost.sv
sv/obst_checker.sv
tb/testbench.sv
